// ----- rtl/core/bbs_pkg.sv -----
// bbs_pkg: shared widths, item codes and the decoded operation record
// used by the front end, the queue and the back end of the syndrome block
// no dependencies
package bbs_pkg;

   localparam int WORD_W       = 64;
   localparam int STORE_WORDS  = 128;
   localparam int WORD_IDX_W   = $clog2(STORE_WORDS);
   localparam int SHIFT_W      = $clog2(WORD_W);
   localparam int NVALID_W     = $clog2(WORD_W + 1);
   localparam int BLOCK_IDX_W  = 7;
   localparam int ROW_NUM_W    = 8;
   localparam int QUEUE_DEPTH  = 4;

   localparam int REQ_FIELDS_W = WORD_IDX_W + WORD_W + BLOCK_IDX_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_FIELDS_W = ROW_NUM_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int DEF_BLOCK_WIDTH = 256;
   localparam int DEF_BLOCK_ROWS  = 256;
   localparam int DEF_ROW_BITS    = 5413;
   localparam int DEF_COL_BITS    = 1547;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_CHUNK = 2'd2
   } req_kind_type;

   // addr is the load word index, or the first error word of a chunk window
   typedef struct packed {
      req_kind_type            kind;
      logic [WORD_IDX_W-1:0]   addr;
      logic [SHIFT_W-1:0]      shift;
      logic [NVALID_W-1:0]     nvalid;
      logic                    row_end;
      logic [WORD_W-1:0]       payload;
   } op_type;

endpackage

// ----- rtl/core/bbs_ram.sv -----
// bbs_ram: generic memory, one write port and two registered read ports
// no dependencies
module bbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/core/bbs_front.sv -----
// bbs_front: accepts request items, tracks the selected column block and
// decodes each item into an op_type record for the queue; uses bbs_pkg
module bbs_front #(
   parameter int BLOCK_WIDTH = bbs_pkg::DEF_BLOCK_WIDTH,
   parameter int ROW_BITS    = bbs_pkg::DEF_ROW_BITS,
   parameter int COL_BITS    = bbs_pkg::DEF_COL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bbs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                          req_tlast,
   input  logic                          q_full,
   output logic                          push,
   output bbs_pkg::op_type               push_op
);
   import bbs_pkg::*;

   localparam int WS_W  = $clog2(63 * BLOCK_WIDTH + 1);
   localparam int POS_W = $clog2(63 * BLOCK_WIDTH + (STORE_WORDS * WORD_W) + COL_BITS);

   logic [WS_W-1:0]        win_start_ff, win_start_in;
   logic                   enabled_ff, enabled_in;

   logic [WORD_IDX_W-1:0]  word_index;
   logic [WORD_W-1:0]      payload;
   logic [BLOCK_IDX_W-1:0] column_block;
   logic                   accept;
   logic [POS_W-1:0]       chunk_off, rel, base, lim_blk, lim_row, lim;
   logic [NVALID_W-1:0]    nvalid;

   assign word_index   = req_tdata[WORD_IDX_W-1:0];
   assign payload      = req_tdata[WORD_IDX_W+WORD_W-1:WORD_IDX_W];
   assign column_block = req_tdata[WORD_IDX_W+WORD_W+BLOCK_IDX_W-1:WORD_IDX_W+WORD_W];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // window geometry of a chunk
   always_comb begin
      chunk_off = POS_W'({word_index, {SHIFT_W{1'b0}}});
      rel       = POS_W'(win_start_ff) + chunk_off;
      base      = rel + POS_W'(COL_BITS);
      if (chunk_off >= POS_W'(BLOCK_WIDTH)) begin
         lim_blk = '0;
      end else begin
         lim_blk = POS_W'(BLOCK_WIDTH) - chunk_off;
      end
      if (rel >= POS_W'(ROW_BITS)) begin
         lim_row = '0;
      end else begin
         lim_row = POS_W'(ROW_BITS) - rel;
      end
      lim = (lim_blk < lim_row) ? lim_blk : lim_row;
      if (!enabled_ff) begin
         nvalid = '0;
      end else if (lim >= POS_W'(WORD_W)) begin
         nvalid = NVALID_W'(WORD_W);
      end else begin
         nvalid = lim[NVALID_W-1:0];
      end
   end

   always_comb begin
      push_op.kind    = req_kind_type'(req_tuser);
      push_op.addr    = base[WORD_IDX_W+SHIFT_W-1:SHIFT_W];
      push_op.shift   = base[SHIFT_W-1:0];
      push_op.nvalid  = nvalid;
      push_op.row_end = req_tlast;
      push_op.payload = payload;
      push            = 1'b0;
      win_start_in    = win_start_ff;
      enabled_in      = enabled_ff;
      case (req_tuser)
         REQ_LOAD: begin
            push         = accept;
            push_op.addr = word_index;
         end
         REQ_START: begin
            push = accept;
            if (accept) begin
               if (column_block[BLOCK_IDX_W-1]) begin
                  enabled_in   = 1'b0;
                  win_start_in = '0;
               end else begin
                  enabled_in   = 1'b1;
                  win_start_in = WS_W'(column_block[BLOCK_IDX_W-2:0]) * WS_W'(BLOCK_WIDTH);
               end
            end
         end
         REQ_CHUNK: begin
            push = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         enabled_ff   <= 1'b0;
      end else begin
         win_start_ff <= win_start_in;
         enabled_ff   <= enabled_in;
      end
   end

endmodule

// ----- rtl/core/bbs_queue.sv -----
// bbs_queue: short first-in first-out queue of decoded op_type records
// between the front end and the back end; uses bbs_pkg
module bbs_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  bbs_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output bbs_pkg::op_type head_op
);
   import bbs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/bbs_back.sv -----
// bbs_back: executes queued ops; error store access, window extraction,
// row parity accumulation and the result register; uses bbs_pkg, bbs_ram
module bbs_back #(
   parameter int BLOCK_ROWS = bbs_pkg::DEF_BLOCK_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  bbs_pkg::op_type                head_op,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bbs_pkg::*;

   logic                   stall;
   logic                   wr_en;
   logic [WORD_IDX_W-1:0]  rd_addr_b;
   logic [WORD_W-1:0]      rd_data_a, rd_data_b;

   logic                   s2_valid_ff, s2_valid_in;
   req_kind_type           s2_kind_ff, s2_kind_in;
   logic                   s2_row_end_ff, s2_row_end_in;
   logic [SHIFT_W-1:0]     s2_shift_ff, s2_shift_in;
   logic [NVALID_W-1:0]    s2_nvalid_ff, s2_nvalid_in;
   logic [WORD_W-1:0]      s2_payload_ff, s2_payload_in;

   logic                   s3_valid_ff, s3_valid_in;
   req_kind_type           s3_kind_ff, s3_kind_in;
   logic                   s3_row_end_ff, s3_row_end_in;
   logic [WORD_W-1:0]      s3_prod_ff, s3_prod_in;

   logic                   parity_ff, parity_in;
   logic [ROW_NUM_W-1:0]   row_cnt_ff, row_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROW_NUM_W-1:0]   rsp_row_ff, rsp_row_in;
   logic                   rsp_bit_ff, rsp_bit_in;

   logic [2*WORD_W-1:0]    pair;
   logic [WORD_W-1:0]      window, mask;
   logic                   chunk_parity;

   assign stall     = rsp_valid_ff && !rsp_tready;
   assign pop       = head_valid && !stall;
   assign wr_en     = pop && (head_op.kind == REQ_LOAD);
   assign rd_addr_b = head_op.addr + WORD_IDX_W'(1);

   bbs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (head_op.addr),
      .wr_data   (head_op.payload),
      .rd_en     (!stall),
      .rd_addr_a (head_op.addr),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // window of error bits starting at the chunk's bit offset
   always_comb begin
      pair   = {rd_data_b, rd_data_a} >> s2_shift_ff;
      window = pair[WORD_W-1:0];
      if (s2_nvalid_ff == NVALID_W'(WORD_W)) begin
         mask = '1;
      end else begin
         mask = (WORD_W'(1) << s2_nvalid_ff) - WORD_W'(1);
      end
   end

   assign chunk_parity = ^s3_prod_ff;

   always_comb begin
      s2_valid_in   = s2_valid_ff;
      s2_kind_in    = s2_kind_ff;
      s2_row_end_in = s2_row_end_ff;
      s2_shift_in   = s2_shift_ff;
      s2_nvalid_in  = s2_nvalid_ff;
      s2_payload_in = s2_payload_ff;
      s3_valid_in   = s3_valid_ff;
      s3_kind_in    = s3_kind_ff;
      s3_row_end_in = s3_row_end_ff;
      s3_prod_in    = s3_prod_ff;
      parity_in     = parity_ff;
      row_cnt_in    = row_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_bit_in    = rsp_bit_ff;
      if (!stall) begin
         s2_valid_in   = pop;
         s2_kind_in    = head_op.kind;
         s2_row_end_in = head_op.row_end;
         s2_shift_in   = head_op.shift;
         s2_nvalid_in  = head_op.nvalid;
         s2_payload_in = head_op.payload;
         s3_valid_in   = s2_valid_ff;
         s3_kind_in    = s2_kind_ff;
         s3_row_end_in = s2_row_end_ff;
         s3_prod_in    = window & mask & s2_payload_ff;
         rsp_valid_in  = 1'b0;
         if (s3_valid_ff) begin
            case (s3_kind_ff)
               REQ_START: begin
                  parity_in  = 1'b0;
                  row_cnt_in = '0;
               end
               REQ_CHUNK: begin
                  if (s3_row_end_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = row_cnt_ff;
                     rsp_bit_in   = parity_ff ^ chunk_parity;
                     parity_in    = 1'b0;
                     row_cnt_in   = (row_cnt_ff == ROW_NUM_W'(BLOCK_ROWS - 1)) ?
                                    '0 : row_cnt_ff + ROW_NUM_W'(1);
                  end else begin
                     parity_in = parity_ff ^ chunk_parity;
                  end
               end
               default: begin
                  parity_in = parity_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff    <= s2_kind_in;
      s2_row_end_ff <= s2_row_end_in;
      s2_shift_ff   <= s2_shift_in;
      s2_nvalid_ff  <= s2_nvalid_in;
      s2_payload_ff <= s2_payload_in;
      s3_kind_ff    <= s3_kind_in;
      s3_row_end_ff <= s3_row_end_in;
      s3_prod_ff    <= s3_prod_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_bit_ff    <= rsp_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         parity_ff    <= 1'b0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         parity_ff    <= parity_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_bit_ff, rsp_row_ff});

endmodule

// ----- rtl/core/binary_block_syndrome_top.sv -----
// binary_block_syndrome_top: syndrome slice of one column block, front end,
// op queue and back end; uses bbs_pkg, bbs_front, bbs_queue, bbs_back
// path of a row-ending chunk: queue entry, s2 store read, s3 product, rsp register
// throughput: one item per cycle while the queue has room, set by the combinational
// front decode and the two-port error store read; a 4-entry queue absorbs rsp stalls
// reset: synchronous, active high; clears block selection, parity and row count,
// the error store keeps no reset and needs no clearing pass
module binary_block_syndrome_top #(
   parameter int BLOCK_WIDTH = bbs_pkg::DEF_BLOCK_WIDTH,
   parameter int BLOCK_ROWS  = bbs_pkg::DEF_BLOCK_ROWS,
   parameter int ROW_BITS    = bbs_pkg::DEF_ROW_BITS,
   parameter int COL_BITS    = bbs_pkg::DEF_COL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // word_index[6:0], payload[70:7], column_block[77:71], zero fill
   input  logic [bbs_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [bbs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // row_number[7:0], syndrome_bit[8], zero fill
   output logic [bbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bbs_pkg::*;

   logic   q_full;
   logic   push;
   op_type push_op;
   logic   pop;
   logic   head_valid;
   op_type head_op;

   bbs_front #(
      .BLOCK_WIDTH (BLOCK_WIDTH),
      .ROW_BITS    (ROW_BITS),
      .COL_BITS    (COL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_op    (push_op)
   );

   bbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   bbs_back #(
      .BLOCK_ROWS (BLOCK_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/core/bbs_checker.sv -----
// bbs_checker: port-level checks of the syndrome block and its bind
// uses bbs_pkg, attaches to binary_block_syndrome_top
module bbs_checker #(
   parameter int BLOCK_ROWS = bbs_pkg::DEF_BLOCK_ROWS
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp item right after reset");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[ROW_NUM_W-1:0] < ROW_NUM_W'(BLOCK_ROWS - 1))
                     || (rsp_tdata[ROW_NUM_W-1:0] == ROW_NUM_W'(BLOCK_ROWS - 1)))
      else $error("row number beyond block rows");

   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W] == '0))
      else $error("rsp fill bits not zero");

endmodule

bind binary_block_syndrome_top bbs_checker #(.BLOCK_ROWS(BLOCK_ROWS)) u_bbs_checker (.*);

// ----- tb/binary_block_syndrome_checker.sv -----
`timescale 1ns / 100ps
// binary_block_syndrome_checker: watches the req and rsp streams of the syndrome block,
// predicts each row's syndrome bit and compares it with the returned item
// depends on bbs_pkg for widths and item codes
module binary_block_syndrome_checker #(
   parameter int BLOCK_WIDTH = bbs_pkg::DEF_BLOCK_WIDTH,
   parameter int BLOCK_ROWS  = bbs_pkg::DEF_BLOCK_ROWS,
   parameter int ROW_BITS    = bbs_pkg::DEF_ROW_BITS,
   parameter int COL_BITS    = bbs_pkg::DEF_COL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bbs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             pending,
   output int                             rows_checked
);
   import bbs_pkg::*;

   typedef struct packed {
      logic [ROW_NUM_W-1:0] row_number;
      logic                 syndrome_bit;
   } syndrome_item_type;

   syndrome_item_type syndrome_queue[$];

   logic [WORD_W-1:0] error_words [STORE_WORDS];
   int unsigned       window_base = 0;
   bit                block_on = 0;
   bit                row_parity = 0;
   int unsigned       row_count = 0;
   int                fails = 0;
   int                checked = 0;
   int                open_count = 0;

   assign fail_count   = fails;
   assign pending      = open_count;
   assign rows_checked = checked;

   // error window bits that line up with one 64-bit chunk of the row
   function automatic logic [WORD_W-1:0] window_bits(input logic [WORD_IDX_W-1:0] chunk);
      logic [WORD_W-1:0] bits;
      int unsigned       j;
      int unsigned       off;
      int unsigned       pos;
      bits = '0;
      for (int k = 0; k < WORD_W; k++) begin
         j   = WORD_W * int'(chunk) + k;
         off = window_base + j;
         if (j < BLOCK_WIDTH && off < ROW_BITS) begin
            pos     = off + COL_BITS;
            bits[k] = error_words[(pos / WORD_W) % STORE_WORDS][pos % WORD_W];
         end
      end
      return bits;
   endfunction

   always @(posedge clock) begin
      syndrome_item_type        want;
      syndrome_item_type        got;
      logic [WORD_IDX_W-1:0]    idx;
      logic [WORD_W-1:0]        data;
      logic [BLOCK_IDX_W-1:0]   blk;
      if (reset) begin
         window_base = 0;
         block_on    = 0;
         row_parity  = 0;
         row_count   = 0;
         syndrome_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.row_number   = rsp_tdata[ROW_NUM_W-1:0];
            got.syndrome_bit = rsp_tdata[ROW_NUM_W];
            if (syndrome_queue.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected rsp item row %0d bit %0d", $time,
                           got.row_number, got.syndrome_bit);
            end else begin
               want = syndrome_queue.pop_front();
               checked++;
               if (got.row_number !== want.row_number ||
                   got.syndrome_bit !== want.syndrome_bit) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: row item %0d: expected row %0d bit %0d, got row %0d bit %0d",
                              $time, checked, want.row_number, want.syndrome_bit,
                              got.row_number, got.syndrome_bit);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx  = req_tdata[WORD_IDX_W-1:0];
            data = req_tdata[WORD_IDX_W +: WORD_W];
            blk  = req_tdata[WORD_IDX_W + WORD_W +: BLOCK_IDX_W];
            case (req_kind_type'(req_tuser))
               REQ_LOAD: error_words[idx] = data;
               REQ_START: begin
                  if (blk[BLOCK_IDX_W-1]) begin
                     block_on    = 0;
                     window_base = 0;
                  end else begin
                     block_on    = 1;
                     window_base = int'(blk) * BLOCK_WIDTH;
                  end
                  row_parity = 0;
                  row_count  = 0;
               end
               REQ_CHUNK: begin
                  if (block_on)
                     row_parity ^= ^(data & window_bits(idx));
                  if (req_tlast) begin
                     want.row_number   = row_count[ROW_NUM_W-1:0];
                     want.syndrome_bit = row_parity;
                     syndrome_queue.push_back(want);
                     row_parity = 0;
                     row_count  = (row_count + 1) % 256;
                     if (row_count >= BLOCK_ROWS)
                        row_count = 0;
                  end
               end
               default: ;
            endcase
         end
      end
      open_count <= syndrome_queue.size();
   end

endmodule

// ----- tb/binary_block_syndrome_top_test.sv -----
`timescale 1ns / 100ps
// binary_block_syndrome_top_test: drives error loads, block starts and row chunks into
// binary_block_syndrome_top with random gaps and stalls; binary_block_syndrome_checker judges
// the rsp items, this module gives the verdict; depends on bbs_pkg
module binary_block_syndrome_top_test;
   import bbs_pkg::*;

   localparam logic [REQ_USER_W-1:0] KIND_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 100;
   localparam int ITEM_TARGET    = 1250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int rows_checked;

   int kind_sent[4] = '{0, 0, 0, 0};
   int items_sent = 0;
   int burst_left = 0;
   int drains = 0;
   int hold_asks = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   binary_block_syndrome_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   binary_block_syndrome_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .rows_checked (rows_checked)
   );

   // rsp side stalls on its own pattern, plus long holds on request
   always @(posedge clock) begin
      if (hold_served != hold_asks) begin
         hold_served <= hold_asks;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 64);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("binary_block_syndrome_top: mismatch");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one item in the current burst and wait until it is taken
   task automatic send_item(input logic [REQ_USER_W-1:0] code,
                            input logic [WORD_IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] data,
                            input logic [BLOCK_IDX_W-1:0] blk,
                            input logic last);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1, 2: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(4, 12);
         endcase
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, blk, data, idx};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      kind_sent[code]++;
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      drains++;
   endtask

   task automatic run_block(input int rows, input bit short_rows);
      logic [BLOCK_IDX_W-1:0] blk;
      logic [WORD_IDX_W-1:0]  idx;
      int                     n;
      case ($urandom_range(0, 19))
         0, 1, 2: blk = 7'($urandom_range(64, 127));
         3, 4, 5: blk = 7'($urandom_range(22, 63));
         default: blk = 7'($urandom_range(0, 21));
      endcase
      send_item(REQ_START, 7'($urandom), rand_word(), blk, 1'($urandom));
      for (int r = 0; r < rows; r++) begin
         if (short_rows)
            n = 1;
         else
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 4;
         for (int c = 0; c < n; c++) begin
            if ($urandom_range(0, 29) == 0)
               send_item(REQ_LOAD, 7'($urandom), rand_word(), 7'($urandom), 1'($urandom));
            if ($urandom_range(0, 39) == 0)
               send_item(KIND_SPARE, 7'($urandom), rand_word(), 7'($urandom), 1'($urandom));
            if (short_rows)
               idx = 7'($urandom_range(0, 3));
            else
               case ($urandom_range(0, 9))
                  0: idx = 7'($urandom);
                  1: idx = 7'($urandom_range(0, 3));
                  default: idx = 7'(c);
               endcase
            send_item(REQ_CHUNK, idx, rand_word(), 7'($urandom), c == n - 1);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the whole error store before any window is read
      for (int w = 0; w < STORE_WORDS; w++)
         send_item(REQ_LOAD, 7'(w), rand_word(), '0, 1'b0);

      // directed: disabled rows, full and partial windows, chunks past the block
      send_item(REQ_CHUNK, 7'd0, '1, '0, 1'b1);
      send_item(REQ_START, '0, '0, 7'd0, 1'b0);
      for (int c = 0; c < 4; c++)
         send_item(REQ_CHUNK, 7'(c), '1, '0, c == 3);
      send_item(REQ_CHUNK, 7'd127, '1, '0, 1'b1);
      send_item(REQ_CHUNK, 7'd1, '1, '0, 1'b0);
      send_item(REQ_CHUNK, 7'd1, {$urandom, $urandom}, '0, 1'b1);
      send_item(REQ_START, '1, '1, 7'd21, 1'b1);
      for (int c = 0; c < 4; c++)
         send_item(REQ_CHUNK, 7'(c), '1, '1, c == 3);
      send_item(REQ_START, '0, '0, 7'd63, 1'b0);
      send_item(REQ_CHUNK, 7'd0, '1, '0, 1'b1);
      send_item(REQ_START, '0, '0, 7'h7f, 1'b0);
      send_item(REQ_CHUNK, 7'd0, '1, '0, 1'b1);
      send_item(REQ_START, '0, '0, 7'h40, 1'b0);
      send_item(REQ_CHUNK, 7'd2, '1, '0, 1'b1);
      send_item(KIND_SPARE, '1, '1, '1, 1'b1);
      send_item(REQ_LOAD, 7'd127, '1, '0, 1'b0);
      send_item(REQ_LOAD, 7'd24, '0, '0, 1'b0);
      send_item(REQ_START, '0, '0, 7'd0, 1'b0);
      send_item(REQ_CHUNK, 7'd0, '1, '0, 1'b1);
      drain_results();

      // long rsp hold while single-chunk rows keep coming; row count wraps
      hold_asks <= hold_asks + 1;
      run_block(260, 1'b1);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         run_block($urandom_range(1, 12), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0)
            drain_results();
      end
      drain_results();
      repeat (10) @(posedge clock);

      $display("covered %0d items: %0d loads, %0d starts, %0d chunks, %0d unused kind",
               items_sent, kind_sent[REQ_LOAD], kind_sent[REQ_START], kind_sent[REQ_CHUNK],
               kind_sent[KIND_SPARE]);
      $display("checked %0d row syndromes across %0d drain pauses and one long rsp hold",
               rows_checked, drains);
      if (fail_count == 0 && pending == 0)
         $display("binary_block_syndrome_top: match");
      else
         $display("binary_block_syndrome_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/bbs_pkg.sv
rtl/core/bbs_ram.sv
rtl/core/bbs_front.sv
rtl/core/bbs_queue.sv
rtl/core/bbs_back.sv
rtl/core/binary_block_syndrome_top.sv
rtl/core/bbs_checker.sv
tb/binary_block_syndrome_checker.sv
tb/binary_block_syndrome_top_test.sv
